// ===== rtl/core/rvss_pkg.sv =====
`default_nettype none

package rvss_pkg;

	localparam int XLEN       = 32;
	localparam int NREGS      = 32;
	localparam int RIDX_W     = $clog2(NREGS);
	localparam int DMEM_WORDS = 4096;
	localparam int DMEM_AW    = $clog2(DMEM_WORDS);

	localparam logic [6:0] OPC_R      = 7'h33;
	localparam logic [6:0] OPC_I      = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JALR   = 7'h67;

	localparam logic [XLEN-1:0] JUMP_MASK = 32'hFFFF_FFFE;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_HALT    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	typedef struct packed {
		logic [1:0]        status;
		logic [XLEN-1:0]   next_pc;
		logic              wb_valid;
		logic [RIDX_W-1:0] wb_index;
		logic [XLEN-1:0]   wb_value;
		logic              store_valid;
		logic [XLEN-1:0]   store_addr;
		logic [XLEN-1:0]   store_data;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rv32i_subset_single_cycle_core.sv =====
// Executes one instruction of a ten-instruction RV32I subset (ADD, SUB, XOR, SRA, ADDI,
// ANDI, LW, SW, BLT, JALR) per request, one request per clock while instr_stall is low; a
// request's register-file reads land in stage 1, a single execute pass and the data-memory
// read land in stage 2, then the result goes into the output queue, with operand forwarding
// between back-to-back instructions. A two-entry output queue lets requests keep flowing
// while one result waits. After reset the data memory is cleared one word per cycle, and
// instr_stall stays high until all DMEM_WORDS words are cleared. Data memory is indexed
// by the unscaled effective address modulo DMEM_WORDS.
`default_nettype none

module rv32i_subset_single_cycle_core import rvss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        instr_valid,
	output logic             instr_stall,
	input  wire logic [31:0] instr_word,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       exec_status,
	output logic [31:0]      next_pc,
	output logic             wb_valid,
	output logic [4:0]       wb_index,
	output logic [31:0]      wb_value,
	output logic             store_valid,
	output logic [31:0]      store_addr,
	output logic [31:0]      store_data
);

	logic                clr_q;
	logic [DMEM_AW-1:0]  clr_cnt_q;
	logic                full;
	logic                adv;
	logic                accept;

	logic                s1_valid_s1;
	logic [XLEN-1:0]     instr_s1;
	logic [XLEN-1:0]     pc_q;
	logic                halted_q;

	logic [XLEN-1:0]     rf_a_rdata;
	logic [XLEN-1:0]     rf_b_rdata;
	logic [NREGS-1:0]    rf_valid_q;
	logic                last_valid_q;
	logic [RIDX_W-1:0]   last_idx_q;
	logic [XLEN-1:0]     last_val_q;

	logic [XLEN-1:0]     op_a;
	logic [XLEN-1:0]     op_b;
	res_t                ex_res;
	logic                ex_load;

	logic                s2_valid_s2;
	res_t                res_s2;
	logic                is_load_s2;
	logic [XLEN-1:0]     dmem_rdata;
	res_t                res_fin;
	logic                rf_we;

	logic                dm_we;
	logic [DMEM_AW-1:0]  dm_waddr;
	logic [XLEN-1:0]     dm_wdata;
	res_t                oq_dout;

	assign adv         = !full;
	assign instr_stall = clr_q || full;
	assign accept      = instr_valid && !instr_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + DMEM_AW'(1);
			if (clr_cnt_q == DMEM_AW'(DMEM_WORDS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (adv) begin
			s1_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			instr_s1 <= instr_word;
		end
	end

	rvss_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (res_s2.wb_index),
		.wdata (res_fin.wb_value),
		.re    (adv),
		.raddr (instr_word[19:15]),
		.rdata (rf_a_rdata)
	);

	rvss_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (res_s2.wb_index),
		.wdata (res_fin.wb_value),
		.re    (adv),
		.raddr (instr_word[24:20]),
		.rdata (rf_b_rdata)
	);

	function automatic logic [XLEN-1:0] operand(
		input logic [RIDX_W-1:0] idx,
		input logic [XLEN-1:0]   ram_data
	);
		logic [XLEN-1:0] v;
		if (idx == '0) begin
			v = '0;
		end else if (s2_valid_s2 && res_s2.wb_valid && res_s2.wb_index == idx) begin
			v = res_fin.wb_value;
		end else if (last_valid_q && last_idx_q == idx) begin
			v = last_val_q;
		end else if (rf_valid_q[idx]) begin
			v = ram_data;
		end else begin
			v = '0;
		end
		return v;
	endfunction

	always_comb begin
		op_a = operand(instr_s1[19:15], rf_a_rdata);
		op_b = operand(instr_s1[24:20], rf_b_rdata);
	end

	rvss_exec u_exec (
		.instr   (instr_s1),
		.pc      (pc_q),
		.halted  (halted_q),
		.op_a    (op_a),
		.op_b    (op_b),
		.res     (ex_res),
		.is_load (ex_load)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halted_q <= 1'b0;
		end else if (adv && s1_valid_s1) begin
			pc_q     <= ex_res.next_pc;
			halted_q <= ex_res.status == ST_HALT;
		end
	end

	// data memory, shared write port with the clear sweep
	assign dm_we    = clr_q || (adv && s1_valid_s1 && ex_res.store_valid);
	assign dm_waddr = clr_q ? clr_cnt_q : ex_res.store_addr[DMEM_AW-1:0];
	assign dm_wdata = clr_q ? '0 : ex_res.store_data;

	rvss_ram #(.WIDTH(XLEN), .DEPTH(DMEM_WORDS)) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (adv),
		.raddr (ex_res.store_addr[DMEM_AW-1:0]),
		.rdata (dmem_rdata)
	);

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (adv) begin
			s2_valid_s2 <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2     <= ex_res;
			is_load_s2 <= ex_load;
		end
	end

	always_comb begin
		res_fin = res_s2;
		if (res_s2.wb_valid && is_load_s2) begin
			res_fin.wb_value = dmem_rdata;
		end
	end

	assign rf_we = adv && s2_valid_s2 && res_s2.wb_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q   <= '0;
			last_valid_q <= 1'b0;
		end else if (rf_we) begin
			rf_valid_q[res_s2.wb_index] <= 1'b1;
			last_valid_q                <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			last_idx_q <= res_s2.wb_index;
			last_val_q <= res_fin.wb_value;
		end
	end

	rvss_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv && s2_valid_s2),
		.din    (res_fin),
		.stall  (result_stall),
		.valid  (result_valid),
		.dout   (oq_dout),
		.full   (full)
	);

	assign exec_status = oq_dout.status;
	assign next_pc     = oq_dout.next_pc;
	assign wb_valid    = oq_dout.wb_valid;
	assign wb_index    = oq_dout.wb_index;
	assign wb_value    = oq_dout.wb_value;
	assign store_valid = oq_dout.store_valid;
	assign store_addr  = oq_dout.store_addr;
	assign store_data  = oq_dout.store_data;

endmodule

`default_nettype wire

// ===== rtl/core/rvss_ram.sv =====
`default_nettype none

module rvss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rvss_exec.sv =====
`default_nettype none

module rvss_exec import rvss_pkg::*; (
	input  wire logic [XLEN-1:0] instr,
	input  wire logic [XLEN-1:0] pc,
	input  wire logic            halted,
	input  wire logic [XLEN-1:0] op_a,
	input  wire logic [XLEN-1:0] op_b,
	output res_t                 res,
	output logic                 is_load
);

	logic [6:0]        opc;
	logic [RIDX_W-1:0] rd;
	logic [XLEN-1:0]   immi;
	logic [XLEN-1:0]   imms;
	logic [XLEN-1:0]   immb;
	logic [XLEN-1:0]   pc_inc;
	logic              wb;
	logic [XLEN-1:0]   val;

	assign opc    = instr[6:0];
	assign rd     = instr[11:7];
	assign immi   = {{20{instr[31]}}, instr[31:20]};
	assign imms   = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign immb   = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign pc_inc = pc + XLEN'(4);

	always_comb begin
		res             = '0;
		res.status      = ST_OK;
		res.next_pc     = pc_inc;
		is_load         = 1'b0;
		wb              = 1'b0;
		val             = '0;
		if (halted || instr == '0) begin
			res.status  = ST_HALT;
			res.next_pc = pc;
		end else begin
			unique case (opc)
				OPC_R: begin
					wb = 1'b1;
					if (instr[12]) begin
						val = $unsigned($signed(op_a) >>> op_b[4:0]);
					end else if (instr[14]) begin
						val = op_a ^ op_b;
					end else if (instr[30]) begin
						val = op_a - op_b;
					end else begin
						val = op_a + op_b;
					end
				end
				OPC_I: begin
					wb  = 1'b1;
					val = instr[14] ? (op_a & immi) : (op_a + immi);
				end
				OPC_LOAD: begin
					wb             = 1'b1;
					is_load        = 1'b1;
					res.store_addr = op_a + immi;
				end
				OPC_STORE: begin
					res.store_valid = 1'b1;
					res.store_addr  = op_a + imms;
					res.store_data  = op_b;
				end
				OPC_BRANCH: begin
					if ($signed(op_a) < $signed(op_b)) begin
						res.next_pc = pc + immb;
					end
				end
				OPC_JALR: begin
					wb          = 1'b1;
					val         = pc_inc;
					res.next_pc = (op_a + immi) & JUMP_MASK;
				end
				default: begin
					res.status = ST_ILLEGAL;
				end
			endcase
		end
		if (wb && rd != '0) begin
			res.wb_valid = 1'b1;
			res.wb_index = rd;
			res.wb_value = val;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rvss_outq.sv =====
`default_nettype none

module rvss_outq import rvss_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t din,
	input  wire logic stall,
	output logic      valid,
	output res_t      dout,
	output logic      full
);

	logic [1:0] cnt_q;
	res_t       head_q;
	res_t       skid_q;
	logic       pop;

	assign valid = cnt_q != 2'd0;
	assign full  = cnt_q == 2'd2;
	assign pop   = valid && !stall;
	assign dout  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (full && pop) begin
			head_q <= skid_q;
		end else if (push && (cnt_q == 2'd0 || pop)) begin
			head_q <= din;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			skid_q <= din;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rvss_checker.sv =====
`default_nettype none

module rvss_checker import rvss_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [1:0]  exec_status,
	input wire logic [31:0] next_pc,
	input wire logic        wb_valid,
	input wire logic [4:0]  wb_index,
	input wire logic [31:0] wb_value,
	input wire logic        store_valid,
	input wire logic [31:0] store_addr,
	input wire logic [31:0] store_data
);

	// halted or illegal instructions change no state
	a_no_side_effect: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (exec_status == ST_HALT || exec_status == ST_ILLEGAL)
		|-> !wb_valid && !store_valid)
		else $error("halt or illegal request wrote state");

	// no write-back reports x0 and an idle write-back is all zero
	a_wb_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (wb_valid ? wb_index != '0 : (wb_index == '0 && wb_value == '0)))
		else $error("bad write-back fields");

	// a store never writes back a register
	a_store_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && store_valid |-> !wb_valid)
		else $error("store with write-back");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(exec_status)
		&& $stable(next_pc) && $stable(wb_value) && $stable(store_addr)
		&& $stable(store_data))
		else $error("stalled result changed");

endmodule

bind rv32i_subset_single_cycle_core rvss_checker u_rvss_checker (.*);

`default_nettype wire

// ===== sim/rv32i_subset_single_cycle_core_test.sv =====
`timescale 1ns / 100ps

module rv32i_subset_single_cycle_core_test;
	import rvss_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_INSTRS = 750;

	logic        clk;
	logic        arst_n;
	logic        instr_valid;
	logic        instr_stall;
	logic [31:0] instr_word;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  exec_status;
	logic [31:0] next_pc;
	logic        wb_valid;
	logic [4:0]  wb_index;
	logic [31:0] wb_value;
	logic        store_valid;
	logic [31:0] store_addr;
	logic [31:0] store_data;

	rv32i_subset_single_cycle_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instr_word(instr_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.exec_status(exec_status),
		.next_pc(next_pc),
		.wb_valid(wb_valid),
		.wb_index(wb_index),
		.wb_value(wb_value),
		.store_valid(store_valid),
		.store_addr(store_addr),
		.store_data(store_data)
	);

	// architectural state of the core as the testbench sees it
	logic [31:0] pc_model;
	logic [31:0] regs_model [NREGS];
	logic [31:0] dmem_model [DMEM_WORDS];
	logic        halted_model;

	res_t pending_results [$];
	res_t want;
	int   err_count;
	int   cycle_count;
	int   idle_pct;
	int   stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] enc_r(input logic alt, input logic [2:0] f3,
			input logic [4:0] rd, input logic [4:0] rs1, input logic [4:0] rs2);
		return {1'b0, alt, 5'd0, rs2, rs1, f3, rd, OPC_R};
	endfunction

	function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
			input logic [4:0] rd, input logic [4:0] rs1, input logic [11:0] imm);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_s(input logic [4:0] rs1, input logic [4:0] rs2,
			input logic [11:0] imm);
		return {imm[11:5], rs2, rs1, 3'b010, imm[4:0], OPC_STORE};
	endfunction

	function automatic logic [31:0] enc_b(input logic [4:0] rs1, input logic [4:0] rs2,
			input logic [12:0] imm);
		return {imm[12], imm[10:5], rs2, rs1, 3'b100, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	// executes one instruction on the local state and returns what the core must report
	function automatic res_t execute_instr(input logic [31:0] w);
		res_t        r;
		logic [31:0] a, b, immi, imms, immb, val;
		logic        wr;
		r = '0;
		wr = 1'b0;
		val = '0;
		a = regs_model[w[19:15]];
		b = regs_model[w[24:20]];
		immi = {{20{w[31]}}, w[31:20]};
		imms = {{20{w[31]}}, w[31:25], w[11:7]};
		immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		r.status = ST_OK;
		r.next_pc = pc_model + 32'd4;
		if (halted_model || w == 32'd0) begin
			r.status = ST_HALT;
			r.next_pc = pc_model;
			halted_model = 1'b1;
		end else begin
			case (w[6:0])
				OPC_R: begin
					wr = 1'b1;
					if (w[12])
						val = $signed(a) >>> b[4:0];
					else if (w[14])
						val = a ^ b;
					else if (w[30])
						val = a - b;
					else
						val = a + b;
				end
				OPC_I: begin
					wr = 1'b1;
					val = w[14] ? (a & immi) : (a + immi);
				end
				OPC_LOAD: begin
					wr = 1'b1;
					r.store_addr = a + immi;
					val = dmem_model[r.store_addr % DMEM_WORDS];
				end
				OPC_STORE: begin
					r.store_addr = a + imms;
					r.store_valid = 1'b1;
					r.store_data = b;
					dmem_model[r.store_addr % DMEM_WORDS] = b;
				end
				OPC_BRANCH: begin
					if ($signed(a) < $signed(b))
						r.next_pc = pc_model + immb;
				end
				OPC_JALR: begin
					wr = 1'b1;
					val = pc_model + 32'd4;
					r.next_pc = (a + immi) & JUMP_MASK;
				end
				default: begin
					r.status = ST_ILLEGAL;
				end
			endcase
		end
		if (wr && w[11:7] != 5'd0) begin
			regs_model[w[11:7]] = val;
			r.wb_valid = 1'b1;
			r.wb_index = w[11:7];
			r.wb_value = val;
		end
		pc_model = r.next_pc;
		return r;
	endfunction

	// sends one request and records its expected outcome once the core takes it
	task automatic send_instr(input logic [31:0] w);
		while ($urandom_range(99) < idle_pct) begin
			instr_valid <= 1'b0;
			@(posedge clk);
		end
		instr_valid <= 1'b1;
		instr_word <= w;
		do @(posedge clk); while (instr_stall !== 1'b0);
		pending_results.push_back(execute_instr(w));
	endtask

	task automatic wait_results_drained();
		instr_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %h, got %h", name, want_v, got_v);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("exec_status", want.status, exec_status);
				check_field("next_pc", want.next_pc, next_pc);
				check_field("wb_valid", want.wb_valid, wb_valid);
				check_field("wb_index", want.wb_index, wb_index);
				check_field("wb_value", want.wb_value, wb_value);
				check_field("store_valid", want.store_valid, store_valid);
				check_field("store_addr", want.store_addr, store_addr);
				check_field("store_data", want.store_data, store_data);
			end
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [31:0] rand_instr();
		logic [31:0] w;
		int          pick;
		w = $urandom;
		pick = $urandom_range(99);
		if (pick < 25) begin
			w[6:0] = OPC_R;
		end else if (pick < 50) begin
			w[6:0] = OPC_I;
		end else if (pick < 62) begin
			w[6:0] = OPC_LOAD;
			// small addresses so loads see earlier stores
			if ($urandom_range(1)) begin
				w[19:15] = 5'd0;
				w[31:20] = 12'($urandom_range(31));
			end
		end else if (pick < 74) begin
			w[6:0] = OPC_STORE;
			if ($urandom_range(1)) begin
				w[19:15] = 5'd0;
				w[31:25] = 7'd0;
				w[11:7] = 5'($urandom_range(31));
			end
		end else if (pick < 84) begin
			w[6:0] = OPC_BRANCH;
		end else if (pick < 90) begin
			w[6:0] = OPC_JALR;
		end else begin
			while (w == 32'd0)
				w = $urandom;
		end
		return w;
	endfunction

	task automatic test_alu();
		send_instr(enc_i(OPC_I, 3'b000, 5'd1, 5'd0, 12'h7FF));
		send_instr(enc_i(OPC_I, 3'b000, 5'd2, 5'd0, 12'h800));
		send_instr(enc_r(1'b0, 3'b000, 5'd3, 5'd1, 5'd2));
		send_instr(enc_r(1'b1, 3'b000, 5'd4, 5'd2, 5'd1));
		send_instr(enc_r(1'b0, 3'b100, 5'd5, 5'd3, 5'd1));
		send_instr(enc_r(1'b1, 3'b101, 5'd6, 5'd2, 5'd1));
		send_instr(enc_i(OPC_I, 3'b111, 5'd7, 5'd4, 12'h7FF));
		// writes to x0 are dropped
		send_instr(enc_i(OPC_I, 3'b000, 5'd0, 5'd1, 12'h005));
		send_instr(enc_r(1'b0, 3'b000, 5'd31, 5'd31, 5'd3));
	endtask

	task automatic test_memory();
		send_instr(enc_s(5'd0, 5'd1, 12'h7FF));
		send_instr(enc_i(OPC_LOAD, 3'b010, 5'd8, 5'd0, 12'h7FF));
		// address wraps onto the same word
		send_instr(enc_s(5'd3, 5'd2, 12'h800));
		send_instr(enc_i(OPC_LOAD, 3'b010, 5'd9, 5'd1, 12'h000));
		send_instr(enc_i(OPC_LOAD, 3'b010, 5'd10, 5'd0, 12'd100));
	endtask

	task automatic test_control();
		send_instr(enc_b(5'd2, 5'd1, 13'd8));
		send_instr(enc_b(5'd1, 5'd2, 13'h1000));
		send_instr(enc_b(5'd1, 5'd1, 13'd4));
		send_instr(enc_b(5'd3, 5'd1, 13'h1000));
		send_instr(enc_i(OPC_JALR, 3'b000, 5'd11, 5'd1, 12'h000));
		send_instr(enc_i(OPC_JALR, 3'b000, 5'd0, 5'd2, 12'hFFF));
	endtask

	task automatic test_illegal();
		send_instr(32'h0000_007F);
		send_instr(32'hFFFF_FFFF);
		send_instr(32'h0000_0037);
	endtask

	task automatic test_random();
		for (int i = 0; i < RANDOM_INSTRS; i++) begin
			if (i == RANDOM_INSTRS / 2)
				wait_results_drained();
			if (i == 450) begin
				idle_pct = 0;
				stall_pct = 0;
			end
			if (i == 600) begin
				idle_pct = 30;
				stall_pct = 30;
			end
			send_instr(rand_instr());
		end
	endtask

	task automatic test_halt();
		send_instr(32'd0);
		for (int i = 0; i < 4; i++)
			send_instr($urandom | 32'd1);
	endtask

	initial begin
		err_count = 0;
		cycle_count = 0;
		idle_pct = 30;
		stall_pct = 30;
		pc_model = '0;
		halted_model = 1'b0;
		foreach (regs_model[i])
			regs_model[i] = '0;
		foreach (dmem_model[i])
			dmem_model[i] = '0;
		arst_n <= 1'b0;
		instr_valid <= 1'b0;
		instr_word <= '0;
		result_stall <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alu();
		test_memory();
		test_control();
		test_illegal();
		test_random();
		test_halt();

		wait_results_drained();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
